### src/pde_pkg.sv
// Shared types and constants for the photon density estimate block.
// Used by the front accumulator, the pixel queue, the divider back end and the top level.
// No dependencies.
`timescale 1ns / 1ps

package pde_pkg;

    // Field widths.
    localparam int DIST_W = 32;
    localparam int FLUX_W = 24;
    localparam int SUM_W  = 32;
    localparam int EST_W  = 18;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((DIST_W + FLUX_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((EST_W + 7) / 8) * 8;

    // Pending pixel queue depth.
    localparam int QUEUE_DEPTH_DEF = 2;

    // round(pi * 2^29)
    localparam logic [30:0] PI_Q29 = 31'd1686629713;

    // Divider geometry: quotient bits produced, and the dividend shift.
    localparam int QBITS    = 18;
    localparam int DIV_SH   = 45;
    localparam int DEN_W    = 63;
    localparam int NUM_W    = SUM_W + DIV_SH;        // magnitude scaled by 2^45
    localparam int REM_W    = DEN_W + QBITS;         // running remainder
    localparam int CNT_W    = $clog2(QBITS);

    // Output limits.
    localparam logic [QBITS-1:0] CAP_HI = 18'd65536;
    localparam logic [QBITS-1:0] CAP_LO = 18'd131072;
    localparam logic signed [EST_W-1:0] EST_HI = 18'sd65536;
    localparam logic signed [EST_W-1:0] EST_LO = -18'sd131072;

    // One finished pixel waiting for its division.
    typedef struct packed {
        logic [DIST_W-1:0]       max_distance;
        logic signed [SUM_W-1:0] flux_sum;
    } pde_entry_t;

    typedef struct packed {
        logic       valid;
        pde_entry_t entry;
    } pde_push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } pde_qstat_t;

    typedef struct packed {
        logic busy;
        logic load;
    } pde_bstat_t;

endpackage

### src/pde_front.sv
// Front end: accumulates the running maximum distance and saturating flux sum of a pixel.
// On the last photon it hands the pixel totals to the queue. Depends on pde_pkg.
`timescale 1ns / 1ps

module pde_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic [pde_pkg::DIST_W-1:0]     squared_distance,
    input  logic signed [pde_pkg::FLUX_W-1:0] photon_flux,
    input  logic                           last_photon,
    output pde_pkg::pde_push_t             push
);
    import pde_pkg::*;

    logic [DIST_W-1:0]       max_reg, max_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [DIST_W-1:0]       max_upd;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_upd;

    always_comb begin
        max_upd  = (squared_distance > max_reg) ? squared_distance : max_reg;
        sum_wide = {sum_reg[SUM_W-1], sum_reg}
                 + {{(SUM_W + 1 - FLUX_W){photon_flux[FLUX_W-1]}}, photon_flux};
        // Clamp to the signed 32-bit range when the two top bits disagree.
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_upd = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_upd = sum_wide[SUM_W-1:0];
        end

        max_next = max_reg;
        sum_next = sum_reg;
        if (accept) begin
            if (last_photon) begin
                max_next = '0;
                sum_next = '0;
            end else begin
                max_next = max_upd;
                sum_next = sum_upd;
            end
        end

        push.valid              = accept && last_photon;
        push.entry.max_distance = max_upd;
        push.entry.flux_sum     = sum_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= '0;
            sum_reg <= '0;
        end else begin
            max_reg <= max_next;
            sum_reg <= sum_next;
        end
    end

endmodule

### src/pde_queue.sv
// Small queue of finished pixel totals between the front and back ends.
// Depends on pde_pkg.
`timescale 1ns / 1ps

module pde_queue #(
    parameter int DEPTH = pde_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pde_pkg::pde_push_t     push,
    input  logic                   pop,
    output pde_pkg::pde_entry_t    head,
    output pde_pkg::pde_qstat_t    stat
);
    import pde_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    pde_entry_t         mem [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W_Q-1:0] cnt_reg, cnt_next;
    logic               do_push, do_pop;

    always_comb begin
        stat.empty = (cnt_reg == '0);
        stat.full  = (cnt_reg == CNT_W_Q'(DEPTH));
        do_push    = push.valid && !stat.full;
        do_pop     = pop && !stat.empty;
        head       = mem[rd_reg];

        wr_next = wr_reg;
        rd_next = rd_reg;
        if (do_push) begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_reg] <= push.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### src/pde_back.sv
// Back end: scales each pixel's flux sum by 1 / (pi * max distance) with a
// multiply, a range check and a one-bit-per-cycle restoring divider. Depends on pde_pkg.
`timescale 1ns / 1ps

module pde_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pde_pkg::pde_entry_t           head,
    input  pde_pkg::pde_qstat_t           qstat,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic signed [pde_pkg::EST_W-1:0] estimate,
    output pde_pkg::pde_bstat_t           stat
);
    import pde_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [SUM_W-1:0]       mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic                   zero_reg, zero_next;
    logic                   sat_reg, sat_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [QBITS-1:0]       q_reg, q_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   ovalid_reg, ovalid_next;
    logic signed [EST_W-1:0] est_reg, est_next;

    logic [REM_W-1:0]       div_d;
    logic [REM_W-1:0]       rem_sub;
    logic                   take;
    logic                   load;
    logic signed [EST_W-1:0] result;

    always_comb begin
        // Divisor aligned to the top quotient bit.
        div_d   = {den_reg, {QBITS{1'b0}}} >> 1;
        take    = (rem_reg >= div_d);
        rem_sub = take ? (rem_reg - div_d) : rem_reg;

        if (zero_reg) begin
            result = '0;
        end else if (sat_reg) begin
            result = neg_reg ? EST_LO : EST_HI;
        end else if (neg_reg) begin
            result = (q_reg > CAP_LO) ? EST_LO : -$signed(q_reg);
        end else begin
            result = (q_reg > CAP_HI) ? EST_HI : $signed(q_reg);
        end

        load = (state_reg == ST_DONE) && (!ovalid_reg || m_tready);

        state_next  = state_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        sat_next    = sat_reg;
        dist_next   = dist_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        pop         = 1'b0;
        ovalid_next = ovalid_reg && !m_tready;
        est_next    = est_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (!qstat.empty) begin
                    pop       = 1'b1;
                    dist_next = head.max_distance;
                    neg_next  = head.flux_sum[SUM_W-1];
                    mag_next  = head.flux_sum[SUM_W-1] ? (~head.flux_sum + 1'b1)
                                                       : head.flux_sum;
                    zero_next = (head.max_distance == '0);
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                den_next   = PI_Q29 * dist_reg;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                q_next   = '0;
                cnt_next = CNT_W'(QBITS - 1);
                rem_next = REM_W'({mag_reg, {DIV_SH{1'b0}}});
                // A quotient of 2^18 or more saturates either way.
                sat_next = ({mag_reg, {(DIV_SH - QBITS){1'b0}}} >= den_reg);
                if (zero_reg || sat_next) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                q_next   = {q_reg[QBITS-2:0], take};
                rem_next = rem_sub << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load) begin
                    ovalid_next = 1'b1;
                    est_next    = result;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        stat.busy = (state_reg != ST_IDLE);
        stat.load = load;
        m_tvalid  = ovalid_reg;
        estimate  = est_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        sat_reg  <= sat_next;
        dist_reg <= dist_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        est_reg  <= est_next;
    end

endmodule

### src/photon_density_estimate.sv
// Top level of the photon density estimate block.
// Instantiates pde_front, pde_queue and pde_back; depends on pde_pkg.
`timescale 1ns / 1ps

// Photons stream in one transaction per cycle, each carrying a squared distance
// (unsigned Q16.16) and a flux (signed Q8.16), with tlast marking a pixel's last
// photon. The front end keeps the pixel's largest distance and a saturating flux
// sum and, on tlast, pushes the totals into a queue of QUEUE_DEPTH pixels. The
// back end turns each queued pixel into flux_sum / (pi * max_distance) in signed
// Q2.16, capped at 1.0 and saturated at -2.0, and 0 when the largest distance is
// 0. In the back end a pixel passes through queue pop, 31x32 multiply, range
// check, 18 restoring divide steps and output load, in that order. A pixel whose
// largest distance is 0, or whose quotient is certain to clip, skips the divide
// steps. Photons are taken at one per cycle while the queue has room; a stream
// of short pixels is limited by the back end, which takes a new pixel only after
// loading the last one's result. The result sits in an output register, so the
// back end can start the next pixel while it waits.
module photon_density_estimate #(
    parameter int QUEUE_DEPTH = pde_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] squared_distance, [55:32] photon_flux
    input  logic [pde_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [17:0] estimate, upper bits zero
    output logic [pde_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pde_pkg::*;

    pde_push_t               push;
    pde_entry_t              head;
    pde_qstat_t              qstat;
    pde_bstat_t              bstat;
    logic                    pop;
    logic                    s_accept;
    logic signed [EST_W-1:0] estimate;

    // New photons are held off only while the queue has no room for a pixel.
    assign s_tready = !qstat.full;
    assign s_accept = s_tvalid && s_tready;

    pde_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (s_accept),
        .squared_distance (s_tdata[DIST_W-1:0]),
        .photon_flux      ($signed(s_tdata[DIST_W+FLUX_W-1:DIST_W])),
        .last_photon      (s_tlast),
        .push             (push)
    );

    pde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .stat    (qstat)
    );

    pde_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .estimate (estimate),
        .stat     (bstat)
    );

    assign m_tdata = {{(M_TDATA_W - EST_W){1'b0}}, estimate};

    // While a result is valid, the estimate never exceeds 1.0; -2.0 is the floor of its width.
    a_est_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (estimate <= EST_HI))
        else $error("estimate above cap");

    // A new result only appears after the back end loaded one.
    a_load_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(bstat.load))
        else $error("output valid without a load");

    // A load happens only while the back end is working on a pixel.
    a_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        bstat.load |-> bstat.busy)
        else $error("load while back end idle");

    // The queue is never reported full and empty at once.
    a_queue_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full |-> !qstat.empty)
        else $error("queue full and empty");

endmodule

### dv/pde_checker.sv
// Scoreboard for the photon density estimate block: watches both stream channels,
// predicts each pixel's estimate and compares it with the result transaction.
// Depends on pde_pkg for the channel widths.
`timescale 1ns / 1ps

module pde_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [pde_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [pde_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            mismatches,
    output int                            estimates_outstanding
);

    localparam longint FLUX_SUM_MAX  = 64'sd2147483647;
    localparam longint FLUX_SUM_MIN  = -64'sd2147483648;
    localparam int     EST_CEIL      = 65536;
    localparam int     EST_FLOOR_MAG = 131072;
    localparam logic [63:0] PI_SCALED = 64'd1686629713;   // pi in Q29

    // Running state of the pixel whose photons are arriving.
    logic [31:0]        pix_max_dist;
    logic signed [31:0] pix_flux_sum;
    logic signed [17:0] pending_estimates[$];
    int                 fail_count = 0;

    // Quotient flux_sum * 2^45 / (pi * max_distance), truncated toward zero, then clipped.
    function automatic logic signed [17:0] density_estimate(input logic [31:0] dmax,
                                                             input logic signed [31:0] fsum);
        logic [31:0]  mag;
        logic [127:0] numer;
        logic [127:0] denom;
        logic [127:0] quot;
        if (dmax == 0) begin
            return '0;
        end
        mag   = fsum[31] ? 32'(-fsum) : fsum;
        numer = 128'(mag) << 45;
        denom = 128'(PI_SCALED) * 128'(dmax);
        quot  = numer / denom;
        if (fsum[31]) begin
            if (quot > EST_FLOOR_MAG) begin
                quot = EST_FLOOR_MAG;
            end
            return 18'(-quot);
        end
        if (quot > EST_CEIL) begin
            quot = EST_CEIL;
        end
        return 18'(quot);
    endfunction

    always @(posedge aclk) begin
        logic [31:0]        photon_dist;
        logic signed [23:0] flux;
        longint             sum;
        logic signed [17:0] want;
        logic signed [17:0] got;
        if (!aresetn) begin
            pix_max_dist = '0;
            pix_flux_sum = '0;
            pending_estimates.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[17:0];
                if (pending_estimates.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result transaction, expected none actual %0d",
                             $time, got);
                end else begin
                    want = pending_estimates.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        $display("%0t: estimate mismatch, expected %0d actual %0d",
                                 $time, want, got);
                    end
                    if (m_tdata[pde_pkg::M_TDATA_W-1:18] !== '0) begin
                        fail_count++;
                        $display("%0t: tdata padding mismatch, expected 0 actual %0h",
                                 $time, m_tdata[pde_pkg::M_TDATA_W-1:18]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                photon_dist = s_tdata[31:0];
                flux        = s_tdata[55:32];
                if (photon_dist > pix_max_dist) begin
                    pix_max_dist = photon_dist;
                end
                sum = longint'(pix_flux_sum) + longint'(flux);
                if (sum > FLUX_SUM_MAX) begin
                    sum = FLUX_SUM_MAX;
                end
                if (sum < FLUX_SUM_MIN) begin
                    sum = FLUX_SUM_MIN;
                end
                pix_flux_sum = 32'(sum);
                if (s_tlast) begin
                    pending_estimates.push_back(density_estimate(pix_max_dist, pix_flux_sum));
                    pix_max_dist = '0;
                    pix_flux_sum = '0;
                end
            end
        end
        mismatches            <= fail_count;
        estimates_outstanding <= pending_estimates.size();
    end

endmodule

### dv/tb_photon_density_estimate.sv
// Top of the photon density estimate testbench: clock, reset, photon stimulus and
// the result-side ready pattern. Depends on pde_pkg, photon_density_estimate and pde_checker.
`timescale 1ns / 1ps

module tb_photon_density_estimate;

    logic                          aclk;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // [31:0] squared_distance, [55:32] photon_flux
    logic [pde_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // [17:0] estimate, upper bits zero
    logic [pde_pkg::M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int estimates_outstanding;

    // When set, neither side inserts idle cycles, so back-to-back traffic is covered too.
    bit calm = 1'b0;

    photon_density_estimate dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pde_checker scoreboard (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_tvalid              (s_tvalid),
        .s_tready              (s_tready),
        .s_tdata               (s_tdata),
        .s_tlast               (s_tlast),
        .m_tvalid              (m_tvalid),
        .m_tready              (m_tready),
        .m_tdata               (m_tdata),
        .mismatches            (mismatches),
        .estimates_outstanding (estimates_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Offers one photon after a random number of idle cycles and returns at the
    // clock edge where the transaction is accepted. The valid stays high when the
    // next photon follows without a gap, so it is never dropped and raised in one step.
    task automatic send_photon(input logic [31:0] sq_dist, input logic [23:0] flux,
                               input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {flux, sq_dist};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // One pixel of ordinary photons. Distances are spread over all magnitudes by a
    // random shift; fluxes are either full-range or shrunk by an arithmetic shift so
    // that many estimates land inside the output range rather than at the clips.
    task automatic send_pixel(input int count, input bit zero_dist, inout int sent);
        logic [31:0]        sq_dist;
        logic signed [23:0] flux;
        for (int i = 0; i < count; i++) begin
            sq_dist = zero_dist ? 32'd0 : ($urandom >> $urandom_range(0, 31));
            flux = 24'($urandom);
            if ($urandom_range(0, 1)) begin
                flux = flux >>> $urandom_range(0, 23);
            end
            send_photon(sq_dist, flux, i == count - 1);
            sent++;
        end
    endtask

    // A pixel of 262 to 275 photons with extreme flux of one sign, so the flux sum
    // saturates; a few photons of the other sign at the end pull it back, which
    // tells a clamped sum from a wrapped one. Large distances keep the estimate
    // inside the output range so the sum is visible in the result.
    task automatic send_long_pixel(input bit negative, inout int sent);
        int                 count;
        logic [23:0]        mag;
        logic signed [23:0] flux;
        count = $urandom_range(262, 275);
        for (int i = 0; i < count; i++) begin
            if (i < count - 4) begin
                flux = negative ? 24'h800000 : 24'h7FFFFF;
            end else begin
                mag  = 24'($urandom_range(0, 16'hFFFF));
                flux = negative ? mag : -mag;
            end
            send_photon($urandom | 32'h8000_0000, flux, i == count - 1);
            sent++;
        end
    endtask

    // Result side: before each result the ready is held low for a random number of
    // cycles, then held high until a result transaction completes.
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int sent;
        int pixel;
        int len;
        sent  = 0;
        pixel = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        // A pixel whose distances are all zero gives zero, whatever its flux.
        send_photon(32'd0, 24'h7FFFFF, 1'b1);
        send_photon(32'd0, 24'h800000, 1'b0);
        send_photon(32'd0, 24'h123456, 1'b1);
        // The smallest distance with the extreme fluxes hits both clips.
        send_photon(32'd1, 24'h7FFFFF, 1'b1);
        send_photon(32'd1, 24'h800000, 1'b1);
        // The largest distance with a unit flux truncates to zero on both signs.
        send_photon(32'hFFFF_FFFF, 24'h000001, 1'b1);
        send_photon(32'hFFFF_FFFF, 24'hFFFFFF, 1'b1);
        // Unit distance and unit flux, both signs: an estimate of 1/pi.
        send_photon(32'h0001_0000, 24'h010000, 1'b1);
        send_photon(32'h0001_0000, 24'hFF0000, 1'b1);
        // The maximum must survive smaller and zero distances before growing again.
        send_photon(32'h0004_0000, 24'h008000, 1'b0);
        send_photon(32'h0000_0010, 24'h008000, 1'b0);
        send_photon(32'h0000_0000, 24'h008000, 1'b0);
        send_photon(32'h0008_0000, 24'hFFF000, 1'b1);
        // Zero flux with a nonzero distance.
        send_photon(32'd0, 24'h000000, 1'b0);
        send_photon(32'h0002_0000, 24'h000000, 1'b1);
        // Fluxes just below and above the upper clip, then around the lower clip.
        send_photon(32'h0001_0000, 24'h03243F, 1'b1);
        send_photon(32'h0001_0000, 24'h032443, 1'b1);
        send_photon(32'h0001_0000, 24'hF9B782, 1'b1);
        send_photon(32'h0001_0000, 24'hF9B780, 1'b1);

        // Random part: mostly short pixels, some of medium length, two that saturate.
        while (sent < 1300) begin
            if ($urandom_range(0, 11) == 0) begin
                calm = !calm;
            end
            if (pixel == 30) begin
                send_long_pixel(1'b0, sent);
            end else if (pixel == 90) begin
                send_long_pixel(1'b1, sent);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                send_pixel(len, $urandom_range(0, 14) == 0, sent);
            end
            pixel++;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Let the scoreboard count the last pixel, drain, then allow for the
        // back end's latency so a stray extra result would still be seen.
        @(posedge aclk);
        while (estimates_outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
src/pde_pkg.sv
src/pde_front.sv
src/pde_queue.sv
src/pde_back.sv
src/photon_density_estimate.sv
dv/pde_checker.sv
dv/tb_photon_density_estimate.sv
